/* rtl/pfsa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pfsa_pkg
// Shared constants, types and helpers of the pinned FIFO slot allocator.
// ----------------------------------------------------------------------------
package pfsa_pkg;

    // table size and derived widths
    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = IDX_W + 1;
    localparam int SLOT_W  = 6;
    localparam int CMP_W   = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    // two-level search: groups of cells, then a pick over the groups
    localparam int GROUP_W = (IDX_W + 1) / 2;
    localparam int GSIZE   = 1 << GROUP_W;
    localparam int GROUPS  = (ENTRIES + GSIZE - 1) / GSIZE;
    localparam int PADDED  = GROUPS * GSIZE;

    typedef logic [IDX_W-1:0]   id_t;
    typedef logic [GROUP_W-1:0] off_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    // request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_PIN   = 1'b1;

    // result status codes
    localparam logic STAT_OK        = 1'b0;
    localparam logic STAT_NONE_FREE = 1'b1;

    // control broadcast to every cell
    typedef struct packed {
        logic  pin_we;
        slot_t pin_idx;
        logic  pin_val;
        logic  move;
        id_t   move_pos;
        id_t   victim_id;
    } cell_ctl_t;

    // registered search result
    typedef struct packed {
        logic found;
        id_t  pos;
        id_t  id;
    } seek_t;

    // one result transaction
    typedef struct packed {
        slot_t slot;
        logic  status;
        logic  reused;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_PICK,
        ST_MOVE,
        ST_EMIT
    } state_t;

    // entry index to the slot field, low bits when the table is wider
    function automatic slot_t to_slot(input id_t v);
        logic [CMP_W-1:0] w;
        w = CMP_W'(v);
        return w[SLOT_W-1:0];
    endfunction

    // entry held by a cell matches a requested index
    function automatic logic same_entry(input id_t id, input slot_t idx);
        return CMP_W'(id) == CMP_W'(idx);
    endfunction

endpackage
`default_nettype wire

/* rtl/pfsa_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pfsa_req_if / pfsa_rsp_if
// Valid/ready channels for requests and results of the slot allocator.
// ----------------------------------------------------------------------------
interface pfsa_req_if;
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [pfsa_pkg::SLOT_W-1:0] entry_index;
    logic                  pinned;

    modport source (output valid, output req_type, output entry_index, output pinned,
                    input ready);
    modport sink   (input valid, input req_type, input entry_index, input pinned,
                    output ready);
endinterface

interface pfsa_rsp_if;
    logic                  valid;
    logic                  ready;
    logic [pfsa_pkg::SLOT_W-1:0] slot;
    logic                  status;
    logic                  reused;

    modport source (output valid, output slot, output status, output reused,
                    input ready);
    modport sink   (input valid, input slot, input status, input reused,
                    output ready);
endinterface
`default_nettype wire

/* rtl/pfsa_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pfsa_cell
// One position of the age list: holds an entry index and its pinned mark,
// takes its neighbor's contents when the list closes a gap.
// ----------------------------------------------------------------------------
module pfsa_cell (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pfsa_pkg::id_t         pos,
    input  wire pfsa_pkg::cell_ctl_t   ctl,
    input  wire pfsa_pkg::id_t         next_id,
    input  wire logic                  next_pin,
    output pfsa_pkg::id_t              id,
    output logic                       pin
);
    import pfsa_pkg::*;

    id_t  id_reg;
    id_t  id_next;
    logic pin_reg;
    logic pin_next;

    // shift from the neighbor at or past the gap, else local pin update
    always_comb
    begin
        id_next  = id_reg;
        pin_next = pin_reg;
        if (ctl.move && (pos >= ctl.move_pos))
        begin
            id_next  = next_id;
            pin_next = next_pin;
        end
        else if (ctl.pin_we && same_entry(id_reg, ctl.pin_idx))
        begin
            pin_next = ctl.pin_val;
        end
    end

    // list starts as issue order, which is identity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg  <= pos;
            pin_reg <= 1'b0;
        end
        else
        begin
            id_reg  <= id_next;
            pin_reg <= pin_next;
        end
    end

    assign id  = id_reg;
    assign pin = pin_reg;

endmodule
`default_nettype wire

/* rtl/pfsa_seek.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pfsa_seek
// Finds the oldest unpinned cell: a registered first-free pick in each group
// of cells, then a registered pick over the groups.
// ----------------------------------------------------------------------------
module pfsa_seek (
    input  wire logic                       clk,
    input  wire pfsa_pkg::id_t              ids [pfsa_pkg::ENTRIES],
    input  wire logic [pfsa_pkg::ENTRIES-1:0] pins,
    output pfsa_pkg::seek_t                 res
);
    import pfsa_pkg::*;

    id_t              pad_id [PADDED];
    logic [PADDED-1:0] pad_pin;

    logic             g_any_next [GROUPS];
    off_t             g_off_next [GROUPS];
    id_t              g_id_next  [GROUPS];
    logic             g_any_reg  [GROUPS];
    off_t             g_off_reg  [GROUPS];
    id_t              g_id_reg   [GROUPS];

    seek_t            res_next;
    seek_t            res_reg;

    // pad the row to whole groups, padding reads as pinned
    genvar e;
    generate
        for (e = 0; e < PADDED; e++)
        begin : g_pad
            if (e < ENTRIES)
            begin : g_real
                assign pad_id[e]  = ids[e];
                assign pad_pin[e] = pins[e];
            end
            else
            begin : g_fill
                assign pad_id[e]  = '0;
                assign pad_pin[e] = 1'b1;
            end
        end
    endgenerate

    // first unpinned cell inside each group
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            g_any_next[g] = 1'b0;
            g_off_next[g] = '0;
            g_id_next[g]  = '0;
            for (int j = GSIZE - 1; j >= 0; j--)
            begin
                if (!pad_pin[g*GSIZE + j])
                begin
                    g_any_next[g] = 1'b1;
                    g_off_next[g] = GROUP_W'(j);
                    g_id_next[g]  = pad_id[g*GSIZE + j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            g_any_reg[g] <= g_any_next[g];
            g_off_reg[g] <= g_off_next[g];
            g_id_reg[g]  <= g_id_next[g];
        end
    end

    // first group that has a free cell
    always_comb
    begin
        res_next = '0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (g_any_reg[g])
            begin
                res_next.found = 1'b1;
                res_next.pos   = IDX_W'(g * GSIZE) + IDX_W'(g_off_reg[g]);
                res_next.id    = g_id_reg[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule
`default_nettype wire

/* rtl/pinned_fifo_slot_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pinned_fifo_slot_allocator
// Hands out table slots in issue order, then reuses the oldest unpinned slot.
// ----------------------------------------------------------------------------
// Every request transaction gives exactly one result transaction. The block
// works on one request at a time. A pin request, or an allocate while unissued
// slots remain, goes from acceptance straight to the emit state and loads the
// output register once that register is free. An allocate once every slot has
// been issued first passes through the find, pick and move states: the
// two-stage registered search for the oldest unpinned cell of the age list,
// then the move state, in which the row of cells closes the gap and puts the
// victim at the newest end. A new request is taken as soon as
// the previous result has entered the output register, even while that result
// still waits downstream. The age list resets to issue order, so no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module pinned_fifo_slot_allocator (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pfsa_req_if.sink    req,
    pfsa_rsp_if.source  rsp
);
    import pfsa_pkg::*;

    state_t    state_reg;
    state_t    state_next;
    cnt_t      count_reg;
    cnt_t      count_next;
    rsp_t      res_reg;
    rsp_t      res_next;
    rsp_t      out_reg;
    logic      out_valid_reg;
    logic      out_valid_next;

    logic      accept;
    logic      not_full;
    logic      out_free;
    logic      load_out;
    cell_ctl_t cell_ctl;
    seek_t     seek;

    id_t               cell_id [ENTRIES];
    logic [ENTRIES-1:0] cell_pin;

    assign accept   = req.valid && req.ready;
    assign not_full = count_reg < CNT_W'(ENTRIES);
    assign out_free = !out_valid_reg || rsp.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if ((req.req_type == REQ_PIN) || not_full)
                        state_next = ST_EMIT;
                    else
                        state_next = ST_FIND;
                end
            end
            ST_FIND: state_next = ST_PICK;
            ST_PICK: state_next = ST_MOVE;
            ST_MOVE: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        req.ready          = 1'b0;
        load_out           = 1'b0;
        cell_ctl.move      = 1'b0;
        unique case (state_reg)
            ST_IDLE: req.ready     = 1'b1;
            ST_MOVE: cell_ctl.move = seek.found;
            ST_EMIT: load_out      = out_free;
            default: ;
        endcase
        cell_ctl.pin_we    = accept && (req.req_type == REQ_PIN);
        cell_ctl.pin_idx   = req.entry_index;
        cell_ctl.pin_val   = req.pinned;
        cell_ctl.move_pos  = seek.pos;
        cell_ctl.victim_id = seek.id;
    end

    // issue count and pending result
    always_comb
    begin
        count_next = count_reg;
        res_next   = res_reg;
        if (accept)
        begin
            if (req.req_type == REQ_PIN)
            begin
                res_next = '{slot: req.entry_index, status: STAT_OK, reused: 1'b0};
            end
            else if (not_full)
            begin
                res_next   = '{slot: to_slot(count_reg[IDX_W-1:0]), status: STAT_OK,
                               reused: 1'b0};
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (state_reg == ST_MOVE)
        begin
            if (seek.found)
                res_next = '{slot: to_slot(seek.id), status: STAT_OK, reused: 1'b1};
            else
                res_next = '{slot: '0, status: STAT_NONE_FREE, reused: 1'b0};
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (load_out)
            out_reg <= res_reg;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.slot   = out_reg.slot;
    assign rsp.status = out_reg.status;
    assign rsp.reused = out_reg.reused;

    // row of cells, oldest at position zero, victim enters at the far end
    genvar i;
    generate
        for (i = 0; i < ENTRIES; i++)
        begin : g_cell
            id_t  nb_id;
            logic nb_pin;
            if (i == ENTRIES - 1)
            begin : g_tail
                assign nb_id  = cell_ctl.victim_id;
                assign nb_pin = 1'b0;
            end
            else
            begin : g_body
                assign nb_id  = cell_id[i+1];
                assign nb_pin = cell_pin[i+1];
            end
            pfsa_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .pos      (IDX_W'(i)),
                .ctl      (cell_ctl),
                .next_id  (nb_id),
                .next_pin (nb_pin),
                .id       (cell_id[i]),
                .pin      (cell_pin[i])
            );
        end
    endgenerate

    // oldest unpinned search
    pfsa_seek u_seek (
        .clk  (clk),
        .ids  (cell_id),
        .pins (cell_pin),
        .res  (seek)
    );

    // the issue count never passes the table size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("issue count above table size");

    // a reused victim lands at the newest end of the list
    a_victim_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOVE) && seek.found |=> cell_id[ENTRIES-1] == $past(seek.id))
        else $error("victim not moved to newest end");

    // the list is only reordered once every slot is issued
    a_move_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOVE) |-> (count_reg == CNT_W'(ENTRIES)))
        else $error("reuse search before table full");

    // a none-free result carries neither a slot nor a reuse flag
    a_none_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && (res_reg.status == STAT_NONE_FREE) |->
            (res_reg.reused == 1'b0) && (res_reg.slot == '0))
        else $error("malformed none-free result");

endmodule
`default_nettype wire

/* sim/pinned_fifo_slot_allocator_test.sv */
// ----------------------------------------------------------------------------
// pinned_fifo_slot_allocator_test
// Self-checking bench for the slot allocator. A behavioral mirror of the age
// list and pin marks predicts every result. Directed tests cover the issue
// order fill, reuse around pinned slots and a fully pinned table. Random
// traffic then runs in chunks of varying pin density and idle pressure.
// ----------------------------------------------------------------------------
module pinned_fifo_slot_allocator_test;
    import pfsa_pkg::*;

    logic clk = 1'b0;
    logic rst_n;

    pfsa_req_if req_if();
    pfsa_rsp_if rsp_if();

    pinned_fifo_slot_allocator u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // free-running clock
    always #4 clk = ~clk;

    // mirror of the allocator state
    id_t  age_list [ENTRIES];
    logic pin_mark [ENTRIES];
    int   issued;
    logic reusing;

    // predicted results, oldest first
    rsp_t expected_slots [$];
    int   errors;
    bit   idle_on;

    // one line per mismatch
    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        errors++;
    endtask

    // per-transaction wait, zero while idling is switched off
    function automatic int draw_wait();
        return idle_on ? int'($urandom_range(0, 4)) : 0;
    endfunction

    // slot result of one request, updates the mirror
    function automatic rsp_t predict_slot(input logic kind, input slot_t idx, input logic pin);
        rsp_t r;
        id_t  victim;
        r.slot   = idx;
        r.status = STAT_OK;
        r.reused = 1'b0;
        if (kind == REQ_PIN)
        begin
            if (int'(idx) < ENTRIES)
                pin_mark[idx] = pin;
            return r;
        end
        // sequential issue until the table is used up
        if (!reusing)
        begin
            if (issued < ENTRIES)
            begin
                victim           = id_t'(issued);
                age_list[issued] = victim;
                issued++;
                r.slot = slot_t'(victim);
                return r;
            end
            reusing = 1'b1;
        end
        // oldest unpinned entry moves to the newest end
        for (int pos = 0; pos < issued; pos++)
        begin
            victim = age_list[pos];
            if (!pin_mark[victim])
            begin
                for (int k = pos; k + 1 < issued; k++)
                    age_list[k] = age_list[k + 1];
                age_list[issued - 1] = victim;
                r.slot   = slot_t'(victim);
                r.reused = 1'b1;
                return r;
            end
        end
        r.slot   = '0;
        r.status = STAT_NONE_FREE;
        return r;
    endfunction

    // drive one request transaction and record its prediction on acceptance
    task automatic send_request(input logic kind, input slot_t idx, input logic pin);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            req_if.valid       <= 1'b0;
            req_if.req_type    <= 1'($urandom);
            req_if.entry_index <= slot_t'($urandom);
            req_if.pinned      <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.req_type    <= kind;
        req_if.entry_index <= idx;
        req_if.pinned      <= pin;
        do
            @(posedge clk);
        while (!req_if.ready);
        expected_slots.push_back(predict_slot(kind, idx, pin));
    endtask

    // result side: random stalls, then compare against the oldest prediction
    initial
    begin : result_check
        rsp_t want;
        int   stall;
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1));
            if (expected_slots.size() == 0)
            begin
                report_mismatch("result with nothing pending, slot", -1, int'(rsp_if.slot));
            end
            else
            begin
                want = expected_slots.pop_front();
                if (rsp_if.slot !== want.slot)
                    report_mismatch("slot", int'(want.slot), int'(rsp_if.slot));
                if (rsp_if.status !== want.status)
                    report_mismatch("status", int'(want.status), int'(rsp_if.status));
                if (rsp_if.reused !== want.reused)
                    report_mismatch("reused", int'(want.reused), int'(rsp_if.reused));
            end
        end
    end

    // pins set before issue, then the full in-order fill
    task automatic test_sequential_fill();
        send_request(REQ_PIN, 6'd0, 1'b1);
        send_request(REQ_PIN, 6'd63, 1'b1);
        send_request(REQ_PIN, 6'd21, 1'b1);
        send_request(REQ_PIN, 6'd42, 1'b0);
        send_request(REQ_PIN, 6'd21, 1'b0);
        for (int i = 0; i < ENTRIES; i++)
            send_request(REQ_ALLOC, slot_t'($urandom), 1'($urandom));
    endtask

    // reuse skips pinned entries and walks the age order
    task automatic test_reuse_order();
        send_request(REQ_ALLOC, 6'd63, 1'b1);
        send_request(REQ_PIN, 6'd2, 1'b1);
        send_request(REQ_ALLOC, 6'd0, 1'b0);
        send_request(REQ_ALLOC, 6'd0, 1'b0);
        send_request(REQ_PIN, 6'd0, 1'b0);
        send_request(REQ_PIN, 6'd63, 1'b0);
        send_request(REQ_PIN, 6'd2, 1'b0);
        send_request(REQ_ALLOC, 6'd0, 1'b0);
        send_request(REQ_ALLOC, 6'd0, 1'b0);
    endtask

    // every entry pinned, then a single entry released
    task automatic test_all_pinned();
        slot_t order [ENTRIES];
        slot_t tmp;
        int    j;
        slot_t loner;
        foreach (order[i])
            order[i] = slot_t'(i);
        for (int i = ENTRIES - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[i])
            send_request(REQ_PIN, order[i], 1'b1);
        send_request(REQ_ALLOC, 6'd0, 1'b0);
        send_request(REQ_ALLOC, 6'd63, 1'b1);
        loner = slot_t'($urandom_range(0, ENTRIES - 1));
        send_request(REQ_PIN, loner, 1'b0);
        send_request(REQ_ALLOC, 6'd0, 1'b0);
        send_request(REQ_ALLOC, 6'd0, 1'b0);
        send_request(REQ_PIN, loner, 1'b1);
        send_request(REQ_ALLOC, 6'd0, 1'b0);
        foreach (order[i])
            send_request(REQ_PIN, order[ENTRIES - 1 - i], 1'b0);
    endtask

    // random mix in chunks of different pin density and idle pressure
    task automatic test_random_traffic();
        int   alloc_pct;
        int   pin_pct;
        logic kind;
        for (int chunk = 0; chunk < 8; chunk++)
        begin
            idle_on   = ($urandom_range(0, 3) != 0);
            alloc_pct = $urandom_range(30, 70);
            case ($urandom_range(0, 2))
                0:       pin_pct = 10;
                1:       pin_pct = 50;
                default: pin_pct = 92;
            endcase
            for (int i = 0; i < 50; i++)
            begin
                kind = ($urandom_range(0, 99) < alloc_pct) ? REQ_ALLOC : REQ_PIN;
                send_request(kind, slot_t'($urandom),
                             ($urandom_range(0, 99) < pin_pct) ? 1'b1 : 1'b0);
            end
        end
        idle_on = 1'b1;
    endtask

    // run sequence
    initial
    begin : run_tests
        int n;
        rst_n              <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.req_type    <= REQ_ALLOC;
        req_if.entry_index <= '0;
        req_if.pinned      <= 1'b0;
        errors  = 0;
        idle_on = 1'b1;
        issued  = 0;
        reusing = 1'b0;
        foreach (pin_mark[i])
            pin_mark[i] = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sequential_fill();
        test_reuse_order();
        test_all_pinned();
        test_random_traffic();
        req_if.valid <= 1'b0;

        // drain outstanding results, bounded
        n = 0;
        while (expected_slots.size() > 0 && n < 2000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (10) @(posedge clk);
        if (expected_slots.size() > 0)
            report_mismatch("results still pending", 0, expected_slots.size());

        if (errors == 0)
            $display("pinned_fifo_slot_allocator_test OK");
        else
            $display("pinned_fifo_slot_allocator_test NOT OK");
        $finish;
    end

    // watchdog
    initial
    begin : watchdog
        #2000000;
        $display("pinned_fifo_slot_allocator_test NOT OK");
        $finish;
    end

endmodule
